FILE: rtl/smm_pkg.sv
// Package for the small matrix multiply block.
// Holds the sequencer state type and the fixed field widths.
// No dependencies.
package smm_pkg;

    // Fixed widths of the request and result fields
    localparam int ELEM_W = 16;
    localparam int PROD_W = 2 * ELEM_W;
    localparam int SUM_W  = 33;
    localparam int IDX_W  = 2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FETCH,
        ST_MULT,
        ST_ACCUM,
        ST_OUT
    } state_t;

endpackage

FILE: rtl/smm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for both operand stores of the matrix multiplier.
// No dependencies.
module smm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 12
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/small_matrix_multiply.sv
// Small matrix multiply: top level. Loads A then B, then streams A*B.
// Depends on smm_pkg and smm_ram.
//
// Send ROWS*INNER elements of A, then INNER*COLS elements of B, both in
// row-major order; element_ready stays high through the load. The request
// that completes B starts the product pass: every entry of A*B is produced in
// row-major order, with its row, its column and a flag on the final entry.
// For each inner term the operands are fetched from the two operand RAMs,
// passed once through the single shared 16x16 multiplier and accumulated;
// the entry is then presented until the consumer takes it. No element
// request is taken until the last product entry has been delivered. Sums
// wrap at 33 bits; at the default 4x3 by 3x4 sizes nothing overflows.
module small_matrix_multiply #(
    parameter int ROWS  = 4,
    parameter int INNER = 3,
    parameter int COLS  = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               element_valid,
    output logic                               element_ready,
    input  logic signed [smm_pkg::ELEM_W-1:0]  element_value,
    output logic                               product_valid,
    input  logic                               product_ready,
    output logic signed [smm_pkg::SUM_W-1:0]   product_value,
    output logic [smm_pkg::IDX_W-1:0]          row_index,
    output logic [smm_pkg::IDX_W-1:0]          col_index,
    output logic                               last_result
);

    import smm_pkg::*;

    localparam int LEFT_COUNT  = ROWS * INNER;
    localparam int RIGHT_COUNT = INNER * COLS;
    localparam int TOTAL_COUNT = LEFT_COUNT + RIGHT_COUNT;
    localparam int LW = $clog2(LEFT_COUNT > 1 ? LEFT_COUNT : 2);
    localparam int BW = $clog2(RIGHT_COUNT > 1 ? RIGHT_COUNT : 2);
    localparam int PW = $clog2(TOTAL_COUNT > 1 ? TOTAL_COUNT : 2);
    localparam int RW = $clog2(ROWS > 1 ? ROWS : 2);
    localparam int CW = $clog2(COLS > 1 ? COLS : 2);
    localparam int KW = $clog2(INNER > 1 ? INNER : 2);

    state_t state_reg, state_next;

    logic [PW-1:0] pos_reg, pos_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [KW-1:0] k_reg, k_next;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  acc_reg, acc_next;

    logic              in_fire;
    logic              out_fire;
    logic              k_last;
    logic              row_last;
    logic              col_last;
    logic              load_left;
    logic              wr_left;
    logic              wr_right;
    logic [LW-1:0]     left_wr_addr;
    logic [BW-1:0]     right_wr_addr;
    logic [LW-1:0]     left_rd_addr;
    logic [BW-1:0]     right_rd_addr;
    logic [ELEM_W-1:0] left_rd_data;
    logic [ELEM_W-1:0] right_rd_data;

    assign in_fire  = element_valid && element_ready;
    assign out_fire = product_valid && product_ready;
    assign k_last   = (k_reg == KW'(INNER - 1));
    assign row_last = (row_reg == RW'(ROWS - 1));
    assign col_last = (col_reg == CW'(COLS - 1));

    // Store addressing during load
    assign load_left     = (pos_reg < PW'(LEFT_COUNT));
    assign wr_left       = in_fire && load_left;
    assign wr_right      = in_fire && !load_left;
    assign left_wr_addr  = LW'(pos_reg);
    assign right_wr_addr = BW'(pos_reg - PW'(LEFT_COUNT));

    // Operand addressing during the product pass: A[r][k], B[k][c]
    assign left_rd_addr  = LW'(row_reg * INNER + k_reg);
    assign right_rd_addr = BW'(k_reg * COLS + col_reg);

    smm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (LEFT_COUNT)
    ) u_left_ram (
        .clk     (clk),
        .wr_en   (wr_left),
        .wr_addr (left_wr_addr),
        .wr_data (element_value),
        .rd_addr (left_rd_addr),
        .rd_data (left_rd_data)
    );

    smm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (RIGHT_COUNT)
    ) u_right_ram (
        .clk     (clk),
        .wr_en   (wr_right),
        .wr_addr (right_wr_addr),
        .wr_data (element_value),
        .rd_addr (right_rd_addr),
        .rd_data (right_rd_data)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire && pos_reg == PW'(TOTAL_COUNT - 1))
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                state_next = k_last ? ST_OUT : ST_FETCH;
            end
            ST_OUT:
            begin
                if (out_fire)
                begin
                    state_next = (row_last && col_last) ? ST_LOAD : ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Outputs and counter updates
    always_comb
    begin
        element_ready = 1'b0;
        product_valid = 1'b0;
        pos_next      = pos_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        k_next        = k_reg;
        acc_next      = acc_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                element_ready = 1'b1;
                if (in_fire)
                begin
                    if (pos_reg == PW'(TOTAL_COUNT - 1))
                    begin
                        pos_next = '0;
                        row_next = '0;
                        col_next = '0;
                        k_next   = '0;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            ST_FETCH, ST_MULT:
            begin
            end
            ST_ACCUM:
            begin
                // first inner term starts a fresh sum
                acc_next = (k_reg == '0 ? '0 : acc_reg)
                           + SUM_W'(prod_reg);
                if (!k_last)
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_OUT:
            begin
                product_valid = 1'b1;
                if (out_fire)
                begin
                    k_next = '0;
                    if (col_last)
                    begin
                        col_next = '0;
                        row_next = row_reg + 1'b1;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            pos_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            k_reg     <= k_next;
        end
    end

    // Shared multiplier and accumulator
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MULT)
        begin
            prod_reg <= $signed(left_rd_data) * $signed(right_rd_data);
        end
        acc_reg <= acc_next;
    end

    // Result fields
    assign product_value = acc_reg;
    assign row_index     = IDX_W'(row_reg);
    assign col_index     = IDX_W'(col_reg);
    assign last_result   = row_last && col_last;

endmodule

FILE: tb/sv/testbench.sv
// Self-checking bench for small_matrix_multiply: streams A then B element requests
// and checks every product entry against an in-bench matrix product model.
// Depends on smm_pkg and the small_matrix_multiply RTL.
`timescale 1ns / 1ps

module testbench;

    import smm_pkg::*;

    localparam int ROWS  = 4;
    localparam int INNER = 3;
    localparam int COLS  = 4;

    localparam int LEFT_COUNT    = ROWS * INNER;
    localparam int RIGHT_COUNT   = INNER * COLS;
    localparam int PAIR_ELEMS    = LEFT_COUNT + RIGHT_COUNT;
    localparam int RANDOM_PAIRS  = 8;
    localparam int QUIET_PAIRS   = 2;
    localparam int PAUSE_AT_PAIR = 3;
    localparam int ENTRY_CYCLES  = 3 * INNER + 1;
    localparam int DRAIN_CYCLES  = 4 * ENTRY_CYCLES;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic signed [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};
    localparam logic signed [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    // INNER * (-32768)^2 at the default sizes
    localparam logic signed [SUM_W-1:0] FULL_SCALE_SUM = 33'h0_C000_0000;

    // Flavors of random matrix pairs
    typedef enum logic [1:0] {
        PAIR_UNIFORM,
        PAIR_EXTREMES,
        PAIR_MIN_PRODUCT,
        PAIR_SMALL
    } pair_kind_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] value;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic                    last;
    } product_entry_t;

    typedef struct {
        logic signed [ELEM_W-1:0] elem;
        bit                       typed;
        logic signed [SUM_W-1:0]  sum;
    } directed_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     element_valid;
    logic                     element_ready;
    logic signed [ELEM_W-1:0] element_value;
    logic                     product_valid;
    logic                     product_ready = 1'b0;
    logic signed [SUM_W-1:0]  product_value;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic                     last_result;

    // Model state: operand stores and load position
    logic signed [ELEM_W-1:0] left_elems [LEFT_COUNT];
    logic signed [ELEM_W-1:0] right_elems [RIGHT_COUNT];
    logic [4:0]               load_pos = '0;

    product_entry_t expected_products [$];
    directed_row_t  directed_table [PAIR_ELEMS];

    bit quiet_phase = 1'b0;
    int stall_left  = 0;
    int idle_cycles = 0;
    int element_count = 0;
    int checked_count = 0;
    int pair_count    = 0;
    int error_count   = 0;

    small_matrix_multiply #(
        .ROWS  (ROWS),
        .INNER (INNER),
        .COLS  (COLS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .element_valid (element_valid),
        .element_ready (element_ready),
        .element_value (element_value),
        .product_valid (product_valid),
        .product_ready (product_ready),
        .product_value (product_value),
        .row_index     (row_index),
        .col_index     (col_index),
        .last_result   (last_result)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Store one accepted element; on the element that completes B, queue all of A*B
    task automatic load_element(input logic signed [ELEM_W-1:0] v, input bit typed,
                                input logic signed [SUM_W-1:0] typed_sum);
        product_entry_t entry;
        longint         acc;
        int             r;
        int             c;
        int             k;
        if (load_pos < LEFT_COUNT)
            left_elems[load_pos] = v;
        else
            right_elems[load_pos - LEFT_COUNT] = v;
        load_pos++;
        if (load_pos == PAIR_ELEMS)
        begin
            load_pos = '0;
            for (r = 0; r < ROWS; r++)
            begin
                for (c = 0; c < COLS; c++)
                begin
                    acc = 0;
                    for (k = 0; k < INNER; k++)
                        acc += longint'(left_elems[r * INNER + k]) *
                               longint'(right_elems[k * COLS + c]);
                    entry.value = typed ? typed_sum : acc[SUM_W-1:0];
                    entry.row   = r[IDX_W-1:0];
                    entry.col   = c[IDX_W-1:0];
                    entry.last  = (r == ROWS - 1) && (c == COLS - 1);
                    expected_products.push_back(entry);
                end
            end
            pair_count++;
        end
    endtask

    // Drive one element request, with an optional idle burst ahead of it
    task automatic send_element(input logic signed [ELEM_W-1:0] v, input bit typed,
                                input logic signed [SUM_W-1:0] typed_sum);
        int gap;
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            element_valid <= 1'b0;
            gap = $urandom_range(1, 16);
            repeat (gap) @(posedge clk);
        end
        element_valid <= 1'b1;
        element_value <= v;
        @(posedge clk);
        while (!element_ready)
            @(posedge clk);
        load_element(v, typed, typed_sum);
        element_count++;
    endtask

    function automatic logic signed [ELEM_W-1:0] random_element(input pair_kind_t kind,
                                                                input bit in_left);
        logic signed [ELEM_W-1:0] v;
        case (kind)
            PAIR_UNIFORM:
                v = ELEM_W'($urandom);
            PAIR_EXTREMES:
                case ($urandom_range(0, 4))
                    0:       v = ELEM_MIN;
                    1:       v = ELEM_MAX;
                    2:       v = '0;
                    3:       v = '1;
                    default: v = ELEM_W'($urandom);
                endcase
            PAIR_MIN_PRODUCT:
                v = in_left ? ELEM_MIN : ELEM_MAX;
            default:
                v = ELEM_W'(int'($urandom_range(0, 15)) - 8);
        endcase
        return v;
    endfunction

    task automatic compare_field(input string field, input longint want, input longint got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            error_count++;
        end
    endtask

    // Consumer side: random stall bursts on product_ready
    always @(posedge clk)
    begin
        if (quiet_phase)
            product_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            product_ready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            product_ready <= 1'b0;
            stall_left    <= $urandom_range(0, 15);
        end
        else
            product_ready <= 1'b1;
    end

    // Result checker
    always @(posedge clk)
    begin
        product_entry_t want;
        if (rst_n && product_valid && product_ready)
        begin
            if (expected_products.size() == 0)
            begin
                $display("%0t: unexpected product entry row %0d col %0d value %0d",
                         $time, row_index, col_index, product_value);
                error_count++;
            end
            else
            begin
                want = expected_products.pop_front();
                compare_field("product_value", longint'($signed(want.value)),
                              longint'(product_value));
                compare_field("row_index", longint'(want.row), longint'(row_index));
                compare_field("col_index", longint'(want.col), longint'(col_index));
                compare_field("last_result", longint'(want.last), longint'(last_result));
                checked_count++;
            end
        end
    end

    // Watchdog: cycles with no request or result taken
    always @(posedge clk)
    begin
        if (!rst_n || (element_valid && element_ready) || (product_valid && product_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("small_matrix_multiply: mismatch");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        int         p;
        int         i;
        pair_kind_t kind;
        rst_n         = 1'b0;
        element_valid = 1'b0;
        element_value = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed pair: A and B all most-negative, so every entry is full scale
        for (i = 0; i < PAIR_ELEMS; i++)
        begin
            directed_table[i].elem  = ELEM_MIN;
            directed_table[i].typed = (i == PAIR_ELEMS - 1);
            directed_table[i].sum   = FULL_SCALE_SUM;
        end
        for (i = 0; i < PAIR_ELEMS; i++)
            send_element(directed_table[i].elem, directed_table[i].typed,
                         directed_table[i].sum);

        // Random pairs; the first one hits the most negative sum
        for (p = 0; p < RANDOM_PAIRS; p++)
        begin
            if (p == PAUSE_AT_PAIR)
            begin
                element_valid <= 1'b0;
                while (expected_products.size() != 0)
                    @(posedge clk);
                @(posedge clk);
            end
            quiet_phase <= (p >= RANDOM_PAIRS - QUIET_PAIRS);
            kind = (p == 0) ? PAIR_MIN_PRODUCT : pair_kind_t'($urandom_range(0, 3));
            for (i = 0; i < PAIR_ELEMS; i++)
                send_element(random_element(kind, i < LEFT_COUNT), 1'b0, '0);
        end
        element_valid <= 1'b0;

        while (expected_products.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d element requests over %0d matrix pairs, %0d product entries checked,",
                 element_count, pair_count, checked_count);
        $display("full-scale extremes, random and small operands, with stalls on both sides");
        if (error_count == 0)
            $display("small_matrix_multiply: match");
        else
            $display("small_matrix_multiply: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/smm_pkg.sv
rtl/smm_ram.sv
rtl/small_matrix_multiply.sv
tb/sv/testbench.sv
